// ===== hw/rtl/twed_pkg.sv =====
`default_nettype none

package twed_pkg;

  localparam int unsigned TIME_BITS_DEF = 32;
  localparam int unsigned LOCK_W        = 8;
  localparam logic [LOCK_W-1:0] LOCK_RESET = 8'd5;

  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned DUTY_W  = 16;
  localparam int unsigned DIST_W  = 32;

  localparam logic signed [7:0] PCT_MAX   = 8'sd100;
  localparam logic signed [7:0] PCT_MIN   = -8'sd100;
  localparam logic [DUTY_W-1:0] DUTY_STEP = 16'd655;

  // mm = floor(total * 129591 / 25000) = 5*total + floor(floor(total*4591/8) / 3125)
  localparam int unsigned FRAC_W   = 45;
  localparam logic [12:0] FRAC_MUL = 13'd4591;
  localparam int unsigned DIG_W    = 14;
  localparam int unsigned REM_W    = 12;
  localparam int unsigned WIN_W    = REM_W + DIG_W;
  localparam logic [REM_W-1:0] DIV_D = 12'd3125;
  localparam int unsigned RECIP_SH = 38;
  localparam logic [26:0] RECIP_M  = 27'd87960931;
  localparam int unsigned PROD_W   = WIN_W + 27;

  // stage 0 is the state itself, stage PIPE_DEPTH-1 is the output register
  localparam int unsigned PIPE_DEPTH = 8;

  typedef enum logic [1:0] {
    ReqTick  = 2'd0,
    ReqEnc   = 2'd1,
    ReqDrive = 2'd2,
    ReqFold  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    DirStop = 2'd0,
    DirFwd  = 2'd1,
    DirRev  = 2'd3
  } dir_e;

  typedef struct packed {
    logic              in1_a;
    logic              in2_a;
    logic [DUTY_W-1:0] duty_a;
    logic              in1_b;
    logic              in2_b;
    logic [DUTY_W-1:0] duty_b;
    logic [COUNT_W-1:0] count_a;
    logic [COUNT_W-1:0] count_b;
    logic              edge_accepted;
    logic              drive_rejected;
  } side_t;

  // floor(w / 3125) for w < 3125 * 2^14
  function automatic logic [DIG_W-1:0] div_d(input logic [WIN_W-1:0] w);
    logic [PROD_W-1:0] p;
    p = PROD_W'(w) * PROD_W'(RECIP_M);
    return p[RECIP_SH+DIG_W-1:RECIP_SH];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/twed_core.sv =====
`default_nettype none

module twed_core #(
  parameter int unsigned TimeBits = twed_pkg::TIME_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [twed_pkg::LOCK_W-1:0]   cfg_wdata_i,
  input  logic                          ld_i,
  input  logic [1:0]                    req_type_i,
  input  logic                          wheel_i,
  input  logic                          edge_level_i,
  input  logic signed [7:0]             drive_a_i,
  input  logic signed [7:0]             drive_b_i,
  output twed_pkg::side_t               side_o,
  output logic [twed_pkg::TOTAL_W-1:0]  total_a_o,
  output logic [twed_pkg::TOTAL_W-1:0]  total_b_o
);
  import twed_pkg::*;

  logic [LOCK_W-1:0]   lock_q;
  logic [TimeBits-1:0] time_q, time_d;
  logic [TimeBits-1:0] last_q [2];
  logic [TimeBits-1:0] last_d [2];
  logic                prev_q [2];
  logic                prev_d [2];
  logic [COUNT_W-1:0]  pend_q [2];
  logic [COUNT_W-1:0]  pend_d [2];
  logic [TOTAL_W-1:0]  total_q [2];
  logic [TOTAL_W-1:0]  total_d [2];
  dir_e                dir_q [2];
  dir_e                dir_d [2];
  logic [DUTY_W-1:0]   pow_q [2];
  logic [DUTY_W-1:0]   pow_d [2];
  logic                acc_q, acc_d;
  logic                rej_q, rej_d;

  logic [TimeBits-1:0] due;
  logic                ok_a, ok_b;
  logic [7:0]          mag_a, mag_b;
  dir_e                cmd_dir_a, cmd_dir_b;
  logic [DUTY_W-1:0]   cmd_pow_a, cmd_pow_b;

  function automatic dir_e cmd_dir(input logic signed [7:0] pct);
    dir_e d;
    if (pct == 8'sd0) begin
      d = DirStop;
    end else if (pct[7]) begin
      d = DirRev;
    end else begin
      d = DirFwd;
    end
    return d;
  endfunction

  always_comb begin
    ok_a      = (drive_a_i >= PCT_MIN) && (drive_a_i <= PCT_MAX);
    ok_b      = (drive_b_i >= PCT_MIN) && (drive_b_i <= PCT_MAX);
    mag_a     = drive_a_i[7] ? 8'(-drive_a_i) : 8'(drive_a_i);
    mag_b     = drive_b_i[7] ? 8'(-drive_b_i) : 8'(drive_b_i);
    cmd_pow_a = DUTY_W'(mag_a[6:0]) * DUTY_STEP;
    cmd_pow_b = DUTY_W'(mag_b[6:0]) * DUTY_STEP;
    cmd_dir_a = cmd_dir(drive_a_i);
    cmd_dir_b = cmd_dir(drive_b_i);
    due       = last_q[wheel_i] + TimeBits'(lock_q);
  end

  always_comb begin
    time_d  = time_q;
    last_d  = last_q;
    prev_d  = prev_q;
    pend_d  = pend_q;
    total_d = total_q;
    dir_d   = dir_q;
    pow_d   = pow_q;
    acc_d   = 1'b0;
    rej_d   = 1'b0;
    unique case (req_e'(req_type_i))
      ReqTick: begin
        time_d = time_q + TimeBits'(1);
      end
      ReqEnc: begin
        if ((edge_level_i != prev_q[wheel_i]) && (time_q >= due)) begin
          prev_d[wheel_i] = edge_level_i;
          pend_d[wheel_i] = pend_q[wheel_i] + COUNT_W'(1);
          last_d[wheel_i] = time_q;
          acc_d           = 1'b1;
        end
      end
      ReqDrive: begin
        if (ok_a) begin
          dir_d[0] = cmd_dir_a;
          pow_d[0] = cmd_pow_a;
        end
        if (ok_a && ok_b) begin
          dir_d[1] = cmd_dir_b;
          pow_d[1] = cmd_pow_b;
        end
        rej_d = !(ok_a && ok_b);
      end
      ReqFold: begin
        for (int i = 0; i < 2; i++) begin
          total_d[i] = total_q[i] + TOTAL_W'(pend_q[i]);
          pend_d[i]  = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_q <= LOCK_RESET;
    end else if (cfg_we_i) begin
      lock_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
      acc_q  <= 1'b0;
      rej_q  <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        last_q[i]  <= '0;
        prev_q[i]  <= 1'b0;
        pend_q[i]  <= '0;
        total_q[i] <= '0;
        dir_q[i]   <= DirStop;
        pow_q[i]   <= '0;
      end
    end else if (ld_i) begin
      time_q  <= time_d;
      acc_q   <= acc_d;
      rej_q   <= rej_d;
      last_q  <= last_d;
      prev_q  <= prev_d;
      pend_q  <= pend_d;
      total_q <= total_d;
      dir_q   <= dir_d;
      pow_q   <= pow_d;
    end
  end

  // bridge pins follow the stored motor state
  always_comb begin
    side_o = '0;
    if ((dir_q[0] != DirStop) && (pow_q[0] != '0)) begin
      side_o.in1_a  = (dir_q[0] != DirFwd);
      side_o.in2_a  = (dir_q[0] == DirFwd);
      side_o.duty_a = pow_q[0];
    end
    if ((dir_q[1] != DirStop) && (pow_q[1] != '0)) begin
      side_o.in1_b  = (dir_q[1] != DirFwd);
      side_o.in2_b  = (dir_q[1] == DirFwd);
      side_o.duty_b = pow_q[1];
    end
    side_o.count_a        = total_q[0][COUNT_W-1:0];
    side_o.count_b        = total_q[1][COUNT_W-1:0];
    side_o.edge_accepted  = acc_q;
    side_o.drive_rejected = rej_q;
  end

  assign total_a_o = total_q[0];
  assign total_b_o = total_q[1];

endmodule

`default_nettype wire

// ===== hw/rtl/twed_dist.sv =====
`default_nettype none

module twed_dist (
  input  logic                                  clk_i,
  input  logic [twed_pkg::PIPE_DEPTH-1:1]       en_i,
  input  logic [twed_pkg::TOTAL_W-1:0]          total_i,
  output logic [twed_pkg::DIST_W-1:0]           dist_o
);
  import twed_pkg::*;

  localparam int unsigned ZW = FRAC_W - 3;

  logic [FRAC_W-1:0]  y1_q;
  logic [DIST_W-1:0]  base1_q, base2_q, base3_q, base4_q, base5_q, base6_q;
  logic [ZW-1:0]      z;
  logic [DIG_W-1:0]   w0_q;
  logic [DIG_W-1:0]   q0_2_q, q0_3_q, q0_4_q, q0_5_q, q0_6_q;
  logic [2*DIG_W-1:0] zlo2_q, zlo3_q;
  logic [DIG_W-1:0]   zlo4_q, zlo5_q;
  logic [REM_W-1:0]   r0_q, r1_q;
  logic [WIN_W-1:0]   w1, w1_q, w2;
  logic [DIG_W-1:0]   q1_4_q, q1_5_q, q1_6_q, q2_q;
  logic [3*DIG_W-1:0] quo;
  logic [DIST_W-1:0]  dist_q;

  assign z   = y1_q[FRAC_W-1:3];
  assign w1  = {r0_q, zlo3_q[2*DIG_W-1:DIG_W]};
  assign w2  = {r1_q, zlo5_q};
  assign quo = {q0_6_q, q1_6_q, q2_q};

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      y1_q    <= FRAC_W'(total_i) * FRAC_W'(FRAC_MUL);
      base1_q <= (total_i << 2) + total_i;
    end
    if (en_i[2]) begin
      w0_q    <= z[ZW-1:2*DIG_W];
      q0_2_q  <= div_d(WIN_W'(z[ZW-1:2*DIG_W]));
      zlo2_q  <= z[2*DIG_W-1:0];
      base2_q <= base1_q;
    end
    if (en_i[3]) begin
      r0_q    <= REM_W'(WIN_W'(w0_q) - WIN_W'(q0_2_q) * WIN_W'(DIV_D));
      q0_3_q  <= q0_2_q;
      zlo3_q  <= zlo2_q;
      base3_q <= base2_q;
    end
    if (en_i[4]) begin
      w1_q    <= w1;
      q1_4_q  <= div_d(w1);
      q0_4_q  <= q0_3_q;
      zlo4_q  <= zlo3_q[DIG_W-1:0];
      base4_q <= base3_q;
    end
    if (en_i[5]) begin
      r1_q    <= REM_W'(w1_q - WIN_W'(q1_4_q) * WIN_W'(DIV_D));
      q1_5_q  <= q1_4_q;
      q0_5_q  <= q0_4_q;
      zlo5_q  <= zlo4_q;
      base5_q <= base4_q;
    end
    if (en_i[6]) begin
      q2_q    <= div_d(w2);
      q1_6_q  <= q1_5_q;
      q0_6_q  <= q0_5_q;
      base6_q <= base5_q;
    end
    if (en_i[7]) begin
      dist_q  <= base6_q + quo[DIST_W-1:0];
    end
  end

  assign dist_o = dist_q;

endmodule

`default_nettype wire

// ===== hw/rtl/two_wheel_encoder_and_hbridge_drive_top.sv =====
`default_nettype none

// Two-wheel encoder counter and H-bridge drive. Each input word (tick, encoder level
// sample, drive command or fold) yields one result word with both bridges' pins and
// duties, the low 16 bits of both encoder totals and the travelled millimetres. A new
// word is accepted every cycle unless in_stall_o is high; results pass through the core
// state and the distance pipeline (a multiply by 4591 and three 14-bit steps of reciprocal
// division by 3125). Bubbles in the pipeline are squeezed out under stall. The user writes
// lockout_ticks through cfg_we_i/cfg_wdata_i while the block is idle; the block does not enforce it.
module two_wheel_encoder_and_hbridge_drive_top #(
  parameter int unsigned TimeBits = twed_pkg::TIME_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [twed_pkg::LOCK_W-1:0]    cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     req_type_i,
  input  logic                           wheel_i,
  input  logic                           edge_level_i,
  input  logic signed [7:0]              drive_a_i,
  input  logic signed [7:0]              drive_b_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           in1_a_o,
  output logic                           in2_a_o,
  output logic [twed_pkg::DUTY_W-1:0]    duty_a_o,
  output logic                           in1_b_o,
  output logic                           in2_b_o,
  output logic [twed_pkg::DUTY_W-1:0]    duty_b_o,
  output logic [twed_pkg::COUNT_W-1:0]   count_a_o,
  output logic [twed_pkg::COUNT_W-1:0]   count_b_o,
  output logic [twed_pkg::DIST_W-1:0]    dist_a_o,
  output logic [twed_pkg::DIST_W-1:0]    dist_b_o,
  output logic                           edge_accepted_o,
  output logic                           drive_rejected_o
);
  import twed_pkg::*;

  localparam int unsigned Last = PIPE_DEPTH - 1;

  logic [PIPE_DEPTH-1:0] v_q, v_d;
  logic [PIPE_DEPTH-1:0] adv;
  logic                  accept;
  logic                  out_fire;
  side_t                 core_side;
  side_t                 side_q [1:Last];
  side_t                 res;
  logic [TOTAL_W-1:0]    total_a, total_b;

  always_comb begin
    adv[Last] = !v_q[Last] || !out_stall_i;
    for (int k = Last - 1; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign in_stall_o = !adv[0];
  assign accept     = in_valid_i && adv[0];
  assign out_fire   = v_q[Last] && !out_stall_i;

  always_comb begin
    v_d[0] = adv[0] ? accept : v_q[0];
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      v_d[k] = adv[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  twed_core #(
    .TimeBits(TimeBits)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ld_i        (accept),
    .req_type_i  (req_type_i),
    .wheel_i     (wheel_i),
    .edge_level_i(edge_level_i),
    .drive_a_i   (drive_a_i),
    .drive_b_i   (drive_b_i),
    .side_o      (core_side),
    .total_a_o   (total_a),
    .total_b_o   (total_b)
  );

  twed_dist u_dist_a (
    .clk_i  (clk_i),
    .en_i   (adv[Last:1]),
    .total_i(total_a),
    .dist_o (dist_a_o)
  );

  twed_dist u_dist_b (
    .clk_i  (clk_i),
    .en_i   (adv[Last:1]),
    .total_i(total_b),
    .dist_o (dist_b_o)
  );

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      side_q[1] <= core_side;
    end
    for (int k = 2; k <= Last; k++) begin
      if (adv[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign res              = side_q[Last];
  assign out_valid_o      = v_q[Last];
  assign in1_a_o          = res.in1_a;
  assign in2_a_o          = res.in2_a;
  assign duty_a_o         = res.duty_a;
  assign in1_b_o          = res.in1_b;
  assign in2_b_o          = res.in2_b;
  assign duty_b_o         = res.duty_b;
  assign count_a_o        = res.count_a;
  assign count_b_o        = res.count_b;
  assign edge_accepted_o  = res.edge_accepted;
  assign drive_rejected_o = res.drive_rejected;

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q))
    else $error("input stalled while pipeline has a bubble");

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !out_fire) |=> ($countones(v_q) == $past($countones(v_q)) + 1))
    else $error("accepted word not tracked in pipeline");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !accept) |=> ($countones(v_q) + 1 == $past($countones(v_q))))
    else $error("delivered word not removed from pipeline");

endmodule

`default_nettype wire
